// ----- sv/vertex_skinning_blend_core_assert.svh -----
// ----------------------------------------------------------------------------
// vertex skinning blend assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef VERTEX_SKINNING_BLEND_CORE_ASSERT_SVH
`define VERTEX_SKINNING_BLEND_CORE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define VSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skinning core check failed");

// consequent must hold in the same cycle as the antecedent
`define VSB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skinning core check failed");

`endif

// ----- sv/vsb_pkg.sv -----
// ----------------------------------------------------------------------------
// vsb_pkg
// beat types, widths and saturation helper for the skinning core
// ----------------------------------------------------------------------------
package vsb_pkg;

    localparam int ELEMS       = 12;
    localparam int LANES       = 4;
    localparam int WEIGHT_BITS = 16;
    localparam int WEIGHT_ONE  = 65536;
    localparam int W_W         = 20;          // signed weight, remainder may go negative
    localparam int PROD_W      = 64;
    localparam int SUM_W       = 66;
    localparam int WPROD_W     = 32 + W_W;
    localparam int ACC_W       = WPROD_W + 2;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_VERTEX = 1'b1
    } vsb_action_t;

    typedef struct packed {
        logic               action;
        logic [3:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [5:0]         bone_a;
        logic [5:0]         bone_b;
        logic [5:0]         bone_c;
        logic [5:0]         bone_d;
        logic [16:0]        weight_a;
        logic [16:0]        weight_b;
        logic [16:0]        weight_c;
    } vsb_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } vsb_out_t;

    // palette element write, broadcast to every lane copy
    typedef struct packed {
        logic               we;
        logic               inr;
        logic [3:0]         slot;
        logic [5:0]         bone;
        logic signed [31:0] data;
    } vsb_wr_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7fffffff);
        lo = -SUM_W'(33'sh080000000);
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ----- sv/vsb_ram.sv -----
// ----------------------------------------------------------------------------
// vsb_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module vsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- sv/vsb_lane.sv -----
// ----------------------------------------------------------------------------
// vsb_lane
// one bone: palette copy, row vector times matrix, weight scaling
// ----------------------------------------------------------------------------
module vsb_lane
    import vsb_pkg::*;
#(
    parameter int BONES     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      en,
    input  vsb_wr_t                   wr,
    input  logic [5:0]                bone,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    input  logic signed [W_W-1:0]     weight,
    output logic signed [WPROD_W-1:0] prod_x,
    output logic signed [WPROD_W-1:0] prod_y,
    output logic signed [WPROD_W-1:0] prod_z
);
    localparam int AW = (BONES > 1) ? $clog2(BONES) : 1;

    logic signed [31:0]        m_rd [ELEMS];
    logic signed [31:0]        p1_reg [3];
    logic signed [W_W-1:0]     w1_reg, w2_reg, w3_reg;
    logic                      inr1_reg, inr2_reg, inr3_reg;
    logic signed [PROD_W-1:0]  pm_reg [9];
    logic signed [PROD_W-1:0]  pm_next [9];
    logic signed [31:0]        m3_reg [3];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic signed [WPROD_W-1:0] wp_reg [3];
    logic signed [WPROD_W-1:0] wp_next [3];
    logic                      inr0;

    assign inr0 = ({3'b000, bone} < 9'(BONES));

    // one memory per matrix element, all read in the same cycle
    for (genvar e = 0; e < ELEMS; e++)
    begin : g_elem
        vsb_ram #(
            .WIDTH (32),
            .DEPTH (BONES)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr.we && wr.inr && (wr.slot == 4'(e))),
            .wr_addr (AW'(wr.bone)),
            .wr_data (wr.data),
            .rd_en   (en),
            .rd_addr (AW'(bone)),
            .rd_data (m_rd[e])
        );
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(64'sd1) <<< (FRAC_BITS - 1);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pm_next[r*3+c] = p1_reg[r] * m_rd[r*3+c];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = SUM_W'(m3_reg[c])
                        + SUM_W'((pm_reg[c]   + half) >>> FRAC_BITS)
                        + SUM_W'((pm_reg[3+c] + half) >>> FRAC_BITS)
                        + SUM_W'((pm_reg[6+c] + half) >>> FRAC_BITS);
            // bone outside the palette reads as a zero matrix
            if (inr3_reg)
            begin
                wp_next[c] = sat32(sum_reg[c]) * w3_reg;
            end
            else
            begin
                wp_next[c] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= pos_x;
            p1_reg[1] <= pos_y;
            p1_reg[2] <= pos_z;
            w1_reg    <= weight;
            inr1_reg  <= inr0;
            pm_reg    <= pm_next;
            for (int c = 0; c < 3; c++)
            begin
                m3_reg[c] <= m_rd[9+c];
            end
            w2_reg    <= w1_reg;
            inr2_reg  <= inr1_reg;
            sum_reg   <= sum_next;
            w3_reg    <= w2_reg;
            inr3_reg  <= inr2_reg;
            wp_reg    <= wp_next;
        end
    end

    assign prod_x = wp_reg[0];
    assign prod_y = wp_reg[1];
    assign prod_z = wp_reg[2];
endmodule

// ----- sv/vsb_merge.sv -----
// ----------------------------------------------------------------------------
// vsb_merge
// sums the weighted lane products, rounds off the weight fraction, saturates
// ----------------------------------------------------------------------------
module vsb_merge
    import vsb_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [WPROD_W-1:0] px [LANES],
    input  logic signed [WPROD_W-1:0] py [LANES],
    input  logic signed [WPROD_W-1:0] pz [LANES],
    output vsb_out_t                  res
);
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic signed [ACC_W-1:0] rnd [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = '0;
        end
        for (int k = 0; k < LANES; k++)
        begin
            acc_next[0] = acc_next[0] + ACC_W'(px[k]);
            acc_next[1] = acc_next[1] + ACC_W'(py[k]);
            acc_next[2] = acc_next[2] + ACC_W'(pz[k]);
        end
        for (int c = 0; c < 3; c++)
        begin
            rnd[c] = (acc_reg[c] + (ACC_W'(1) <<< (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
        end
        res.out_x = sat32(SUM_W'(rnd[0]));
        res.out_y = sat32(SUM_W'(rnd[1]));
        res.out_z = sat32(SUM_W'(rnd[2]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end
endmodule

// ----- sv/vertex_skinning_blend_core.sv -----
// ----------------------------------------------------------------------------
// vertex_skinning_blend_core
// four-bone linear blend skinning in fixed point with an on-chip palette
// ----------------------------------------------------------------------------
// The core takes one beat per cycle on vtx. A load beat (action 0) writes one
// palette element (bone_a, slot) and returns nothing; loads to slot 12..15 or
// to a bone at or above BONES are dropped. A vertex beat (action 1) returns
// one res beat: the position as (x, y, z, 1) times each of four bone
// matrices, weighted by weight_a..c and one minus their sum, summed, rounded
// and saturated to Q16.16. Four lanes each hold a full copy of the palette in
// twelve per-element memories, so all four bones are read in the same cycle;
// the lane pipeline (read, multiply, sum, weight) and the merge stage feed
// the output register. A vertex may read an entry loaded in the previous
// beat. Reading a palette entry never loaded gives an unspecified result.
// The whole pipeline holds while a result sits unread on res.
module vertex_skinning_blend_core
    import vsb_pkg::*;
#(
    parameter int BONES     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vtx_valid,
    output logic     vtx_ready,
    input  vsb_in_t  vtx,
    output logic     res_valid,
    input  logic     res_ready,
    output vsb_out_t res
);
`include "vertex_skinning_blend_core_assert.svh"

    logic                      en;
    logic                      acc_vtx;
    vsb_wr_t                   wr;
    logic [5:0]                bones [LANES];
    logic signed [W_W-1:0]     wts [LANES];
    logic signed [WPROD_W-1:0] px [LANES];
    logic signed [WPROD_W-1:0] py [LANES];
    logic signed [WPROD_W-1:0] pz [LANES];
    vsb_out_t                  merged;
    vsb_out_t                  res_reg;
    logic [4:0]                vld_reg;
    logic [4:0]                vld_next;
    logic                      out_vld_reg;

    // pipeline moves whenever the output register is free or being drained
    assign en        = !out_vld_reg || res_ready;
    assign vtx_ready = en;
    assign acc_vtx   = vtx_valid && en && (vtx.action == ACT_VERTEX);

    // load beats broadcast to every lane copy of the palette
    assign wr.we   = vtx_valid && en && (vtx.action == ACT_LOAD);
    assign wr.inr  = ({3'b000, vtx.bone_a} < 9'(BONES));
    assign wr.slot = vtx.slot;
    assign wr.bone = vtx.bone_a;
    assign wr.data = vtx.pos_x;

    assign bones[0] = vtx.bone_a;
    assign bones[1] = vtx.bone_b;
    assign bones[2] = vtx.bone_c;
    assign bones[3] = vtx.bone_d;

    // remaining weight, negative when the three given ones exceed one
    assign wts[0] = $signed(W_W'(vtx.weight_a));
    assign wts[1] = $signed(W_W'(vtx.weight_b));
    assign wts[2] = $signed(W_W'(vtx.weight_c));
    assign wts[3] = $signed(W_W'(WEIGHT_ONE) - W_W'(vtx.weight_a)
                          - W_W'(vtx.weight_b) - W_W'(vtx.weight_c));

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        vsb_lane #(
            .BONES     (BONES),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .wr     (wr),
            .bone   (bones[k]),
            .pos_x  (vtx.pos_x),
            .pos_y  (vtx.pos_y),
            .pos_z  (vtx.pos_z),
            .weight (wts[k]),
            .prod_x (px[k]),
            .prod_y (py[k]),
            .prod_z (pz[k])
        );
    end

    vsb_merge u_merge (
        .clk (clk),
        .en  (en),
        .px  (px),
        .py  (py),
        .pz  (pz),
        .res (merged)
    );

    // vertex tracking through read, multiply, sum, weight and merge stages
    assign vld_next = {vld_reg[3:0], acc_vtx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= merged;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = res_reg;

    `VSB_ASSERT_NEXT(a_vertex_enters, acc_vtx, vld_reg[0])
    `VSB_ASSERT_NEXT(a_load_no_result, wr.we, !vld_reg[0])
    `VSB_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_reg) && $stable(out_vld_reg))
    `VSB_ASSERT_SAME(a_ready_when_free, !out_vld_reg, vtx_ready)
endmodule
